>>> rtl/core/crc8_frame_checker_macros.svh
// Assertion macros shared by the frame checker's verification files.
// Each macro expects a clock named clk and an active-low reset named arst_n
// in the scope where it is used.
`ifndef CRC8_FRAME_CHECKER_MACROS_SVH
`define CRC8_FRAME_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRC8FC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRC8FC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/crc8fc_pkg.sv
// ----------------------------------------------------------------------------
// crc8fc_pkg
// Types, constants and the CRC-8 update function of the frame checker.
// ----------------------------------------------------------------------------
package crc8fc_pkg;

	localparam logic [7:0] CrcPoly     = 8'h07;
	localparam logic [7:0] CrcInit     = 8'h00;
	localparam logic [7:0] MarkerReset = 8'h7e;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_SIZE    = 3'd1,
		PH_SEQ     = 3'd2,
		PH_TYPE    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CRC     = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       frame_end;
		logic       crc_ok;
		logic [7:0] frame_size;
		logic [7:0] sequence_number;
		logic [7:0] message_type;
	} result_t;

	// One byte through CRC-8, MSB first, no reflection.
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/core/crc8fc_parser.sv
// ----------------------------------------------------------------------------
// crc8fc_parser
// Frame state machine and running CRC; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module crc8fc_parser import crc8fc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic [7:0] frame_marker,
	output result_t    result
);

	phase_t     phase_q, phase_nxt;
	logic [7:0] crc_q, crc_nxt;
	logic [7:0] left_q, left_nxt;
	logic [7:0] size_q, seq_q, type_q;
	logic [7:0] crc_base, crc_fed, left_dec;

	// The marker starts a fresh CRC, so hunting feeds from the initial value.
	assign crc_base = (phase_q == PH_HUNT) ? CrcInit : crc_q;
	assign crc_fed  = crc8_feed(crc_base, rx_byte);
	assign left_dec = left_q - 8'd1;

	// Next state.
	always_comb begin
		phase_nxt = PH_HUNT;
		unique case (phase_q)
			PH_HUNT: begin
				phase_nxt = (rx_byte == frame_marker) ? PH_SIZE : PH_HUNT;
			end
			PH_SIZE:    phase_nxt = PH_SEQ;
			PH_SEQ:     phase_nxt = PH_TYPE;
			PH_TYPE: begin
				phase_nxt = (left_q != 8'd0) ? PH_PAYLOAD : PH_CRC;
			end
			PH_PAYLOAD: begin
				phase_nxt = (left_dec == 8'd0) ? PH_CRC : PH_PAYLOAD;
			end
			PH_CRC:     phase_nxt = PH_HUNT;
			default:    phase_nxt = PH_HUNT;
		endcase
	end

	// Outputs and datapath updates.
	always_comb begin
		result   = '0;
		crc_nxt  = crc_q;
		left_nxt = left_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == frame_marker) begin
					crc_nxt = crc_fed;
				end
			end
			PH_SIZE: begin
				crc_nxt  = crc_fed;
				left_nxt = rx_byte;
			end
			PH_SEQ, PH_TYPE: begin
				crc_nxt = crc_fed;
			end
			PH_PAYLOAD: begin
				result.payload_byte  = rx_byte;
				result.payload_valid = 1'b1;
				crc_nxt              = crc_fed;
				left_nxt             = left_dec;
			end
			PH_CRC: begin
				result.frame_end       = 1'b1;
				result.crc_ok          = (rx_byte == crc_q);
				result.frame_size      = size_q;
				result.sequence_number = seq_q;
				result.message_type    = type_q;
				crc_nxt                = CrcInit;
			end
			default: begin
				crc_nxt = crc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			crc_q   <= CrcInit;
			left_q  <= 8'd0;
			size_q  <= 8'd0;
			seq_q   <= 8'd0;
			type_q  <= 8'd0;
		end else if (step) begin
			phase_q <= phase_nxt;
			crc_q   <= crc_nxt;
			left_q  <= left_nxt;
			if (phase_q == PH_SIZE) begin
				size_q <= rx_byte;
			end
			if (phase_q == PH_SEQ) begin
				seq_q <= rx_byte;
			end
			if (phase_q == PH_TYPE) begin
				type_q <= rx_byte;
			end
		end
	end

endmodule

>>> rtl/core/crc8_frame_checker.sv
// ----------------------------------------------------------------------------
// crc8_frame_checker
// CRC-8 (poly 0x07) frame receiver: hunt, header, payload pass-through, check.
// ----------------------------------------------------------------------------
// Every accepted input beat produces exactly one output beat, and a new
// byte can be taken in every cycle while the input side does not stall.
// The byte is first captured in an input register; once it moves on, the
// frame state machine and the one-byte CRC-8 update (eight shift steps
// flattened into XOR logic) compute the result, which lands in the output
// register. That state and CRC loop, closed in combinational logic, sets
// the rate of one byte per clock. The input side keeps accepting while a
// finished result waits in the output register, and stalls only when both
// the input register and the output register are full. The start marker
// register resets to 0x7e and is meant to be written only while the block
// is idle; a new value applies from the next hunt for a frame.
module crc8_frame_checker import crc8fc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration: start marker byte.
	input  logic       cfg_wen,
	input  logic [7:0] cfg_wdata,
	// Input channel.
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// Output channel.
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic       frame_end,
	output logic       crc_ok,
	output logic [7:0] frame_size,
	output logic [7:0] sequence_number,
	output logic [7:0] message_type
);

	logic [7:0] marker_q;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       valid_s2;
	result_t    result_s2;
	result_t    result_nxt;
	logic       adv_s2;
	logic       step;

	// The output register can take a new beat when it is empty or draining.
	assign adv_s2   = !valid_s2 || !out_stall;
	// The parser moves on exactly when the input register hands its byte on.
	assign step     = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MarkerReset;
		end else if (cfg_wen) begin
			marker_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	crc8fc_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte      (rx_byte_s1),
		.frame_marker (marker_q),
		.result       (result_nxt)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid       = valid_s2;
	assign payload_byte    = result_s2.payload_byte;
	assign payload_valid   = result_s2.payload_valid;
	assign frame_end       = result_s2.frame_end;
	assign crc_ok          = result_s2.crc_ok;
	assign frame_size      = result_s2.frame_size;
	assign sequence_number = result_s2.sequence_number;
	assign message_type    = result_s2.message_type;

endmodule

>>> rtl/core/crc8fc_checker.sv
// ----------------------------------------------------------------------------
// crc8fc_checker
// Port-level checks on the frame checker, attached by bind.
// ----------------------------------------------------------------------------
`include "crc8_frame_checker_macros.svh"

module crc8fc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] payload_byte,
	input logic       payload_valid,
	input logic       frame_end,
	input logic       crc_ok,
	input logic [7:0] frame_size,
	input logic [7:0] sequence_number,
	input logic [7:0] message_type
);

	// A stalled output beat stays and keeps its contents.
	`CRC8FC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(payload_byte) && $stable(payload_valid) && $stable(frame_end) && $stable(crc_ok) && $stable(frame_size) && $stable(sequence_number) && $stable(message_type), "stalled output beat changed")

	// A byte is either payload or the CRC byte, never both.
	`CRC8FC_ASSERT_NOW(a_kind_excl, out_valid, !(payload_valid && frame_end), "payload and frame end together")

	// Header fields and the CRC verdict appear only with the frame end.
	`CRC8FC_ASSERT_NOW(a_hdr_zero, out_valid && !frame_end, !crc_ok && frame_size == 8'd0 && sequence_number == 8'd0 && message_type == 8'd0, "header fields outside frame end")

	// The payload byte is zero unless it carries payload.
	`CRC8FC_ASSERT_NOW(a_pay_zero, out_valid && !payload_valid, payload_byte == 8'd0, "payload byte set without payload")

endmodule

bind crc8_frame_checker crc8fc_checker u_crc8fc_checker (.*);

>>> tb/crc8_frame_checker_tb.sv
// ----------------------------------------------------------------------------
// crc8_frame_checker_tb
// Self-checking testbench for the CRC-8 frame checker. A byte-level model of
// the frame state machine predicts one result beat for every accepted input
// beat; each output beat is compared field by field with the oldest
// prediction. Directed frames come first, then random frames, broken frames
// and line noise under several start markers, with random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module crc8_frame_checker_tb;
	import crc8fc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Predicts the frame checker byte by byte and holds the result beats
	// that are still owed by the block, oldest first.
	class frame_scoreboard;
		phase_t     phase;
		logic [7:0] crc;
		logic [7:0] left;
		logic [7:0] size_h;
		logic [7:0] seq_h;
		logic [7:0] type_h;
		logic [7:0] marker;
		result_t    due[$];
		int         errors;

		function new();
			phase  = PH_HUNT;
			crc    = 8'h00;
			left   = 8'h00;
			size_h = 8'h00;
			seq_h  = 8'h00;
			type_h = 8'h00;
			marker = MarkerReset;
			errors = 0;
		endfunction

		// CRC-8, polynomial 0x07, MSB first.
		static function logic [7:0] crc_next(logic [7:0] cur, logic [7:0] b);
			logic [7:0] c;
			c = cur ^ b;
			for (int k = 0; k < 8; k++) begin
				c = {c[6:0], 1'b0} ^ (c[7] ? CrcPoly : 8'h00);
			end
			return c;
		endfunction

		function void set_marker(logic [7:0] v);
			marker = v;
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Advances the model by one accepted input byte.
		function void note_byte(logic [7:0] b);
			result_t r;
			r = '0;
			case (phase)
				PH_SIZE: begin
					size_h = b;
					left   = b;
					crc    = crc_next(crc, b);
					phase  = PH_SEQ;
				end
				PH_SEQ: begin
					seq_h = b;
					crc   = crc_next(crc, b);
					phase = PH_TYPE;
				end
				PH_TYPE: begin
					type_h = b;
					crc    = crc_next(crc, b);
					phase  = (left != 8'h00) ? PH_PAYLOAD : PH_CRC;
				end
				PH_PAYLOAD: begin
					r.payload_byte  = b;
					r.payload_valid = 1'b1;
					crc  = crc_next(crc, b);
					left = left - 8'd1;
					if (left == 8'h00) begin
						phase = PH_CRC;
					end
				end
				PH_CRC: begin
					r.frame_end       = 1'b1;
					r.crc_ok          = (b == crc);
					r.frame_size      = size_h;
					r.sequence_number = seq_h;
					r.message_type    = type_h;
					crc   = CrcInit;
					phase = PH_HUNT;
				end
				default: begin
					phase = PH_HUNT;
					if (b == marker) begin
						crc   = crc_next(CrcInit, b);
						phase = PH_SIZE;
					end
				end
			endcase
			due.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] e, logic [7:0] a);
			if (e !== a) begin
				$error("%s: expected %0h, actual %0h", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (due.size() == 0) begin
				$error("output beat with no expected result: %p", got);
				errors++;
				return;
			end
			e = due.pop_front();
			compare_field("payload_byte", e.payload_byte, got.payload_byte);
			compare_field("payload_valid", 8'(e.payload_valid), 8'(got.payload_valid));
			compare_field("frame_end", 8'(e.frame_end), 8'(got.frame_end));
			compare_field("crc_ok", 8'(e.crc_ok), 8'(got.crc_ok));
			compare_field("frame_size", e.frame_size, got.frame_size);
			compare_field("sequence_number", e.sequence_number, got.sequence_number);
			compare_field("message_type", e.message_type, got.message_type);
		endfunction
	endclass

	// This bound only catches a hung block.
	localparam int CycleLimit = 300000;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_wen   = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       frame_end;
	logic       crc_ok;
	logic [7:0] frame_size;
	logic [7:0] sequence_number;
	logic [7:0] message_type;

	frame_scoreboard sb;

	// Random idling is switched off for the last part of the run. The main
	// sequence asks the output side for one long hold-off through
	// hold_request; the output process counts that hold-off itself.
	bit gaps_on      = 1'b1;
	bit hold_request = 1'b0;
	int cycles       = 0;

	crc8_frame_checker dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_byte    (payload_byte),
		.payload_valid   (payload_valid),
		.frame_end       (frame_end),
		.crc_ok          (crc_ok),
		.frame_size      (frame_size),
		.sequence_number (sequence_number),
		.message_type    (message_type)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a block that stops handing over beats ends the run here.
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("crc8_frame_checker test failed");
				$finish;
			end
		end
	end

	// Output side. Every sample is taken right after the rising edge, so it
	// sees the values that were present at the edge; out_stall is updated by
	// a nonblocking assignment and so takes effect at the following edge.
	initial begin
		result_t got;
		int      stall_left;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.payload_byte    = payload_byte;
				got.payload_valid   = payload_valid;
				got.frame_end       = frame_end;
				got.crc_ok          = crc_ok;
				got.frame_size      = frame_size;
				got.sequence_number = sequence_number;
				got.message_type    = message_type;
				sb.check_result(got);
			end
			if (hold_request) begin
				// Long hold-off: the sender keeps offering beats, so both
				// internal registers fill and the block stalls its input.
				hold_request = 1'b0;
				stall_left   = 40;
				out_stall   <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				// A burst of stalled cycles of random length.
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one byte and returns at the edge where it is accepted. Called
	// at a rising edge; valid stays high into the next beat unless a gap is
	// inserted, so it is never lowered and raised in the same step.
	task automatic send_byte(input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_byte(b);
	endtask

	task automatic send_seq(input logic [7:0] beats[$]);
		foreach (beats[i]) begin
			send_byte(beats[i]);
		end
	endtask

	// Lays out marker, header, payload and CRC byte. A bad frame gets a CRC
	// byte that differs from the true one.
	function automatic void build_frame(input logic [7:0] mk, input logic [7:0] seq,
			input logic [7:0] typ, input logic [7:0] payload[$], input bit good,
			output logic [7:0] beats[$]);
		logic [7:0] c;
		beats = {mk, 8'(payload.size()), seq, typ};
		foreach (payload[i]) begin
			beats.push_back(payload[i]);
		end
		c = 8'h00;
		foreach (beats[i]) begin
			c = frame_scoreboard::crc_next(c, beats[i]);
		end
		if (!good) begin
			c = c ^ 8'($urandom_range(1, 255));
		end
		beats.push_back(c);
	endfunction

	// Lowers valid and waits until every expected beat has come out, then lets
	// the two pipeline registers settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	// Writes the start marker; only called while the block is idle.
	task automatic write_marker(input logic [7:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_marker(v);
	endtask

	// One random stretch: mostly well-formed frames with random content and
	// small sizes, plus line noise and frames cut off part way. A cut frame
	// swallows whatever follows it, so the next marker may land inside it.
	task automatic run_phase(input int target, input bit with_max_frame);
		logic [7:0] payload[$];
		logic [7:0] beats[$];
		int         sent;
		int         pick;
		int         size;
		sent = 0;
		if (with_max_frame) begin
			payload = {};
			repeat (255) payload.push_back(8'($urandom));
			build_frame(sb.marker, 8'($urandom), 8'($urandom), payload, 1'b1, beats);
			send_seq(beats);
			sent += beats.size();
		end
		while (sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// Line noise; it may happen to equal the marker.
				send_byte(8'($urandom));
			end else begin
				case ($urandom_range(0, 19))
					0:       size = $urandom_range(0, 255) % 48;
					1, 2:    size = $urandom_range(7, 20);
					default: size = $urandom_range(0, 6);
				endcase
				payload = {};
				repeat (size) payload.push_back(8'($urandom));
				build_frame(sb.marker, 8'($urandom), 8'($urandom), payload,
					$urandom_range(0, 3) != 0, beats);
				if (pick == 1) begin
					beats = beats[0:$urandom_range(0, beats.size() - 2)];
				end
				send_seq(beats);
				sent += beats.size();
			end
		end
	endtask

	initial begin
		logic [7:0] payload[$];
		logic [7:0] beats[$];
		sb = new();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset marker. A noise byte is dropped.
		send_byte(8'h00);
		// Empty payload: the byte after the type byte is the CRC byte.
		payload = {};
		build_frame(MarkerReset, 8'hff, 8'h00, payload, 1'b1, beats);
		send_seq(beats);
		// One payload byte and a CRC mismatch.
		payload = {8'hff};
		build_frame(MarkerReset, 8'h00, 8'hff, payload, 1'b0, beats);
		send_seq(beats);
		// A frame cut in two by a marker write: the frame in progress keeps
		// going, and both the old and the new marker inside it are plain data.
		payload = {MarkerReset, 8'ha5};
		build_frame(MarkerReset, 8'h5a, 8'hc3, payload, 1'b1, beats);
		send_seq(beats[0:1]);
		drain();
		write_marker(8'ha5);
		send_seq(beats[2:$]);
		// The new marker opens the next frame.
		payload = {};
		build_frame(8'ha5, 8'h01, 8'h02, payload, 1'b1, beats);
		send_seq(beats);
		drain();

		// Random part, through the marker extremes and a random value.
		write_marker(8'h00);
		hold_request = 1'b1;
		run_phase(210, 1'b0);
		drain();
		write_marker(8'hff);
		run_phase(210, 1'b0);
		drain();
		write_marker(8'($urandom_range(1, 254)));
		run_phase(210, 1'b1);
		drain();

		// Last part at full rate: no idling on either side.
		gaps_on = 1'b0;
		write_marker(MarkerReset);
		run_phase(200, 1'b0);
		in_valid <= 1'b0;

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		// Any stray beat in these cycles is flagged by the output side.
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("crc8_frame_checker test passed");
		end else begin
			$display("crc8_frame_checker test failed");
		end
		$finish;
	end

endmodule
